FILE: sv/lpct_pkg.sv
// ----------------------------------------------------------------------------
// lpct_pkg
// Shared types and constants for the LRU page cache tag row: key width,
// request codes and the structs that run between the cells of the row.
// ----------------------------------------------------------------------------
package lpct_pkg;

    localparam int KEY_W = 16;
    localparam int OCC_W = 3;

    typedef logic [KEY_W-1:0] t_key;
    typedef logic [OCC_W-1:0] t_occ;

    // request codes
    localparam logic REQ_ACCESS = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // contents of one slot, also what a cell hands down to its older neighbor
    typedef struct packed {
        logic valid;
        t_key key;
    } t_slot;

    // controls broadcast to every cell of the row
    typedef struct packed {
        logic step;       // beat accepted, update the row
        logic flush;      // empty the row
        logic full_miss;  // miss on a full row: everything shifts down
        t_key page;       // key of the access
    } t_cell_ctrl;

endpackage

FILE: sv/lru_page_cache_tags.sv
// ----------------------------------------------------------------------------
// lru_page_cache_tags
// Tag and LRU replacement logic of a small fully associative page cache.
// ----------------------------------------------------------------------------
// Each request beat (page access or flush) yields exactly one result beat,
// registered, in the cycle after the request is taken. A new request is taken in
// every cycle in which the result register is empty or being drained, so the
// block sustains one request per cycle; the row of CAPACITY cells does the
// whole compare, shift and append of the LRU order in that single cycle, and
// the cell chain length (CAPACITY) sets the critical path. Slot 0 of the row
// is the least recent entry. A flush empties the cache without reporting
// evictions. Occupancy is reported modulo 8.
module lru_page_cache_tags #(
    parameter int CAPACITY = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_req_type,
    input  lpct_pkg::t_key       i_page_number,
    input  logic                 i_force_render,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_reused,
    output logic                 o_evict_valid,
    output lpct_pkg::t_key       o_evicted_page,
    output lpct_pkg::t_occ       o_occupancy
);
    import lpct_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_slot      w_slot [CAPACITY+1];
    logic       w_seen [CAPACITY+1];
    logic       w_shv  [CAPACITY+1];
    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_flush;
    logic       w_hit;
    logic       w_full;

    logic             r_out_valid;
    logic             r_reused;
    logic             r_evict_valid;
    t_key             r_evicted_page;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // handshake: the result register frees up when drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_flush    = (i_req_type == REQ_FLUSH);

    // chain ends
    assign w_slot[CAPACITY] = '{valid: 1'b0, key: '0};
    assign w_seen[0]        = 1'b0;
    assign w_shv[0]         = 1'b1;

    assign w_hit  = w_seen[CAPACITY];
    assign w_full = w_slot[CAPACITY-1].valid;

    assign w_ctrl = '{step:      w_accept,
                      flush:     w_flush,
                      full_miss: !w_hit && w_full,
                      page:      i_page_number};

    // row of slots, oldest first
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        lpct_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_up         (w_slot[gi+1]),
            .i_seen       (w_seen[gi]),
            .i_prev_valid (w_shv[gi]),
            .o_slot       (w_slot[gi]),
            .o_seen       (w_seen[gi+1]),
            .o_shift_valid(w_shv[gi+1])
        );
    end

    // occupancy: grows only on a miss with room left
    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            if (w_flush) begin
                n_count = '0;
            end else if (!w_hit && !w_full) begin
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_reused       <= !w_flush && w_hit && !i_force_render;
            r_evict_valid  <= !w_flush && !w_hit && w_full;
            r_evicted_page <= (!w_flush && !w_hit && w_full) ? w_slot[0].key : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reused       = r_reused;
    assign o_evict_valid  = r_evict_valid;
    assign o_evicted_page = r_evicted_page;
    assign o_occupancy    = OCC_W'(r_count);

endmodule

FILE: sv/lpct_cell.sv
// ----------------------------------------------------------------------------
// lpct_cell
// One slot of the LRU order row. Compares its key with the access, passes
// the match prefix on to the younger neighbor, and on each beat either keeps
// its entry, takes the entry of its younger neighbor, or takes the new page
// when it is the first empty slot after the shift.
// ----------------------------------------------------------------------------
module lpct_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lpct_pkg::t_cell_ctrl i_ctrl,
    input  lpct_pkg::t_slot     i_up,         // current entry of younger neighbor
    input  logic                i_seen,       // a match was found in an older slot
    input  logic                i_prev_valid, // older neighbor valid after shift
    output lpct_pkg::t_slot     o_slot,       // current entry of this cell
    output logic                o_seen,
    output logic                o_shift_valid
);
    import lpct_pkg::*;

    logic  r_valid;
    t_key  r_key;
    logic  n_valid;
    t_key  n_key;
    logic  w_match;
    logic  w_shift;
    t_slot w_sh;
    logic  w_tail;

    assign o_slot = '{valid: r_valid, key: r_key};

    // match prefix: every slot from the hit upward shifts down
    assign w_match = r_valid && (r_key == i_ctrl.page);
    assign o_seen  = i_seen || w_match;
    assign w_shift = o_seen || i_ctrl.full_miss;

    // entry after the shift, and the append point just past the last valid one
    assign w_sh          = w_shift ? i_up : o_slot;
    assign o_shift_valid = w_sh.valid;
    assign w_tail        = !w_sh.valid && i_prev_valid;

    // next slot contents
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        if (i_ctrl.step) begin
            if (i_ctrl.flush) begin
                n_valid = 1'b0;
            end else if (w_tail) begin
                n_valid = 1'b1;
                n_key   = i_ctrl.page;
            end else begin
                n_valid = w_sh.valid;
                n_key   = w_sh.key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // key needs no reset, an invalid slot is never reported
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

endmodule

FILE: dv/tb_lru_page_cache_tags.sv
// ----------------------------------------------------------------------------
// tb_lru_page_cache_tags
// Self-checking bench for the LRU page cache tag row. Keeps its own LRU list,
// predicts the result beat of every accepted request and compares it field by
// field. A directed part covers the corner cases, then random runs over a
// small hot page set and over the full key range, each under several idle and
// stall mixes on both channels.
// ----------------------------------------------------------------------------
module tb_lru_page_cache_tags;

    timeunit 1ns;
    timeprecision 1ps;

    import lpct_pkg::*;

    localparam int CAPACITY = 6;

    // one result beat
    typedef struct packed {
        logic reused;
        logic evict_valid;
        t_key evicted_page;
        t_occ occupancy;
    } t_outcome;

    // DUT ports
    logic i_clk          = 1'b0;
    logic i_rst_n        = 1'b0;
    logic i_in_valid     = 1'b0;
    logic i_req_type     = REQ_ACCESS;
    t_key i_page_number  = '0;
    logic i_force_render = 1'b0;
    logic i_out_stall    = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    logic o_reused;
    logic o_evict_valid;
    t_key o_evicted_page;
    t_occ o_occupancy;

    // shadow LRU list, slot 0 least recent
    t_key lru_keys [CAPACITY];
    int   lru_fill;

    t_outcome access_outcomes [$];
    int       mismatch_cnt;
    int       send_idle_pct;
    int       stall_pct;

    lru_page_cache_tags #(
        .CAPACITY (CAPACITY)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_page_number  (i_page_number),
        .i_force_render (i_force_render),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_reused       (o_reused),
        .o_evict_valid  (o_evict_valid),
        .o_evicted_page (o_evicted_page),
        .o_occupancy    (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the shadow list and return the beat it yields.
    function automatic t_outcome lru_update(logic req, t_key page, logic frc);
        t_outcome res;
        int       hit_pos;
        res     = '0;
        hit_pos = -1;
        if (req == REQ_FLUSH) begin
            lru_fill = 0;
            foreach (lru_keys[i]) lru_keys[i] = '0;
        end else begin
            for (int i = 0; i < lru_fill; i++) begin
                if (hit_pos < 0 && lru_keys[i] == page) hit_pos = i;
            end
            if (hit_pos >= 0) begin
                // hit or forced refresh: move to most recent
                res.reused = ~frc;
                for (int i = hit_pos; i < lru_fill - 1; i++) lru_keys[i] = lru_keys[i+1];
                lru_keys[lru_fill-1] = page;
            end else begin
                // miss on a full list drops the least recent entry
                if (lru_fill == CAPACITY) begin
                    res.evict_valid  = 1'b1;
                    res.evicted_page = lru_keys[0];
                    for (int i = 0; i < CAPACITY - 1; i++) lru_keys[i] = lru_keys[i+1];
                    lru_fill = CAPACITY - 1;
                end
                lru_keys[lru_fill] = page;
                lru_fill++;
            end
        end
        res.occupancy = t_occ'(lru_fill);
        return res;
    endfunction

    // Send one request beat; valid stays high into the next call unless it idles.
    task automatic send_beat(input logic req, input t_key page, input logic frc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_page_number  <= page;
        i_force_render <= frc;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        access_outcomes.push_back(lru_update(req, page, frc));
    endtask

    // Result checking and receiver stall
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_reused, o_evict_valid, o_evicted_page, o_occupancy};
            if (access_outcomes.size() == 0) begin
                if (mismatch_cnt < 10)
                    $display("%0t: result beat with nothing pending: %p", $realtime, got);
                mismatch_cnt++;
            end else begin
                want = access_outcomes.pop_front();
                if (got.reused !== want.reused || got.evict_valid !== want.evict_valid ||
                    got.evicted_page !== want.evicted_page ||
                    got.occupancy !== want.occupancy) begin
                    if (mismatch_cnt < 10)
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, want, got);
                    mismatch_cnt++;
                end
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    // Corner cases: empty flush, extreme keys, hit, forced refresh, fill, evict
    task automatic test_directed();
        t_key pages [] = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234,
                          16'hA5A5, 16'h5A5A, 16'h8001, 16'h7FFE, 16'h0000, 16'h5A5A,
                          16'h0000, 16'h1234, 16'hFFFF, 16'h0001, 16'h0001, 16'h0000,
                          16'h0000};
        logic reqs  [] = '{REQ_FLUSH, REQ_ACCESS, REQ_ACCESS, REQ_ACCESS, REQ_ACCESS,
                          REQ_ACCESS, REQ_ACCESS, REQ_ACCESS, REQ_ACCESS, REQ_ACCESS,
                          REQ_ACCESS, REQ_ACCESS, REQ_ACCESS, REQ_ACCESS, REQ_FLUSH,
                          REQ_ACCESS, REQ_ACCESS, REQ_FLUSH, REQ_ACCESS};
        logic frcs  [] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                          1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
        foreach (pages[i]) send_beat(reqs[i], pages[i], frcs[i]);
    endtask

    // Accesses mostly within a pool a little larger than the cache: hits,
    // refreshes and evictions all common.
    task automatic test_hot_pages(input int count);
        t_key pool [CAPACITY+2];
        int   pick;
        foreach (pool[i]) pool[i] = t_key'($urandom);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 3)
                send_beat(REQ_FLUSH, t_key'($urandom), 1'($urandom));
            else if (pick < 88)
                send_beat(REQ_ACCESS, pool[$urandom_range(CAPACITY+1)],
                          $urandom_range(99) < 20);
            else
                send_beat(REQ_ACCESS, t_key'($urandom), 1'($urandom));
        end
    endtask

    // Keys over the whole range, mostly misses on a full cache
    task automatic test_wide_keys(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 5)
                send_beat(REQ_FLUSH, t_key'($urandom), 1'($urandom));
            else
                send_beat(REQ_ACCESS, t_key'($urandom), 1'($urandom));
        end
    endtask

    // Test sequence
    initial begin
        int idle_mix [4][2] = '{'{0, 0}, '{59, 0}, '{0, 59}, '{6, 6}};
        int guard;
        mismatch_cnt  = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        lru_fill      = 0;
        foreach (lru_keys[i]) lru_keys[i] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        foreach (idle_mix[p]) begin
            send_idle_pct = idle_mix[p][0];
            stall_pct     = idle_mix[p][1];
            test_hot_pages(150);
            test_wide_keys(75);
        end
        i_in_valid <= 1'b0;

        // drain, then allow for the registered output stage
        guard = 0;
        while (access_outcomes.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
        if (access_outcomes.size() != 0) begin
            $display("%0d result beats never arrived", access_outcomes.size());
            mismatch_cnt += access_outcomes.size();
        end

        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
